### sv/lkt_pkg.sv
`default_nettype none

package lkt_pkg;

    // partial keyword state: letters seen so far
    localparam logic [3:0] PK_IDLE = 4'd0;
    localparam logic [3:0] PK_N    = 4'd1;
    localparam logic [3:0] PK_NO   = 4'd2;
    localparam logic [3:0] PK_A    = 4'd3;
    localparam logic [3:0] PK_AN   = 4'd4;
    localparam logic [3:0] PK_O    = 4'd5;
    localparam logic [3:0] PK_X    = 4'd6;
    localparam logic [3:0] PK_XO   = 4'd7;
    localparam logic [3:0] PK_I    = 4'd8;
    localparam logic [3:0] PK_IF   = 4'd9;
    localparam logic [3:0] PK_T    = 4'd10;
    localparam logic [3:0] PK_TH   = 4'd11;
    localparam logic [3:0] PK_THE  = 4'd12;

    // token codes
    localparam logic [3:0] TOK_NONE  = 4'd0;
    localparam logic [3:0] TOK_VAR   = 4'd1;
    localparam logic [3:0] TOK_NOT   = 4'd2;
    localparam logic [3:0] TOK_AND   = 4'd3;
    localparam logic [3:0] TOK_OR    = 4'd4;
    localparam logic [3:0] TOK_XOR   = 4'd5;
    localparam logic [3:0] TOK_IF    = 4'd6;
    localparam logic [3:0] TOK_THEN  = 4'd7;
    localparam logic [3:0] TOK_IFF   = 4'd8;
    localparam logic [3:0] TOK_LPAR  = 4'd9;
    localparam logic [3:0] TOK_RPAR  = 4'd10;

    // characters
    localparam logic [7:0] CH_EOL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam int unsigned TOK_W = 4;

endpackage

`default_nettype wire

### sv/logic_keyword_tokenizer.sv
// Channel   | Dir | tdata                     | tuser
// ----------+-----+---------------------------+------------------
// s (bytes) | in  | [7:0] character           | [0] start_of_line
// m (token) | out | [3:0] token_code, [7:4] 0 | [0] is_error
//
// One byte per cycle sustained while the result is not stalled; a token passes
// the input register, then the result register, on its way to the result port.
// The keyword state updates in the single cycle a byte moves from the input
// register to the result stage, so consecutive bytes never wait on each other.
// Reset (synchronous, active low) empties both registers, clears the partial
// keyword and the halt flag. A stalled result holds the input register, and
// o_s_tready drops only while the input register holds a byte and a stalled
// result blocks it.
`default_nettype none

module logic_keyword_tokenizer
    import lkt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] character
    input  wire logic       i_s_tuser,   // [0] start_of_line
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [3:0] token_code, [7:4] zero
    output logic            o_m_tuser    // [0] is_error
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_sol;

    logic [3:0]       r_pk, n_pk;
    logic             r_halted, n_halted;

    logic             r_out_valid;
    logic [TOK_W-1:0] r_out_code;
    logic             r_out_err;

    logic             advance;
    logic [3:0]       pk_cur;
    logic             halt_cur;
    logic             use_exp;
    logic [7:0]       exp_char;
    logic [3:0]       exp_next;
    logic [TOK_W-1:0] exp_code;
    logic             res_valid;
    logic [TOK_W-1:0] res_code;
    logic             res_err;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_sol  <= i_s_tuser;
        end
    end

    always_comb begin
        pk_cur    = r_in_sol ? PK_IDLE : r_pk;
        halt_cur  = r_in_sol ? 1'b0 : r_halted;
        n_pk      = r_pk;
        n_halted  = r_halted;
        res_valid = 1'b0;
        res_code  = TOK_NONE;
        res_err   = 1'b0;
        use_exp   = 1'b1;
        exp_char  = CH_EOL;
        exp_next  = PK_IDLE;
        exp_code  = TOK_NONE;

        unique case (pk_cur)
            PK_N:    begin exp_char = CH_O; exp_next = PK_NO;  end
            PK_NO:   begin exp_char = CH_T; exp_code = TOK_NOT; end
            PK_A:    begin exp_char = CH_N; exp_next = PK_AN;  end
            PK_AN:   begin exp_char = CH_D; exp_code = TOK_AND; end
            PK_O:    begin exp_char = CH_R; exp_code = TOK_OR;  end
            PK_X:    begin exp_char = CH_O; exp_next = PK_XO;  end
            PK_XO:   begin exp_char = CH_R; exp_code = TOK_XOR; end
            PK_I:    begin exp_char = CH_F; exp_next = PK_IF;  end
            PK_T:    begin exp_char = CH_H; exp_next = PK_TH;  end
            PK_TH:   begin exp_char = CH_E; exp_next = PK_THE; end
            PK_THE:  begin exp_char = CH_N; exp_code = TOK_THEN; end
            default: use_exp = 1'b0;
        endcase

        if (advance) begin
            n_pk     = pk_cur;
            n_halted = halt_cur;
            if (!halt_cur) begin
                if (use_exp) begin
                    if (r_in_char != exp_char) begin
                        res_valid = 1'b1;
                        res_err   = 1'b1;
                        n_halted  = 1'b1;
                        n_pk      = PK_IDLE;
                    end else if (exp_code != TOK_NONE) begin
                        res_valid = 1'b1;
                        res_code  = exp_code;
                        n_pk      = PK_IDLE;
                    end else begin
                        n_pk = exp_next;
                    end
                end else if (pk_cur == PK_IF) begin
                    // "if" is confirmed by the byte after it
                    n_pk      = PK_IDLE;
                    res_valid = 1'b1;
                    priority if (r_in_char == CH_F) begin
                        res_code = TOK_IFF;
                    end else if (r_in_char == CH_SPACE) begin
                        res_code = TOK_IF;
                    end else if (r_in_char == CH_EOL) begin
                        res_code = TOK_IF;
                        n_halted = 1'b1;
                    end else begin
                        res_err  = 1'b1;
                        n_halted = 1'b1;
                    end
                end else begin
                    n_pk = PK_IDLE;
                    unique case (r_in_char)
                        CH_P, CH_Q, CH_R, CH_S: begin
                            res_valid = 1'b1;
                            res_code  = TOK_VAR;
                        end
                        CH_N:     n_pk = PK_N;
                        CH_A:     n_pk = PK_A;
                        CH_O:     n_pk = PK_O;
                        CH_X:     n_pk = PK_X;
                        CH_I:     n_pk = PK_I;
                        CH_T:     n_pk = PK_T;
                        CH_LPAR: begin
                            res_valid = 1'b1;
                            res_code  = TOK_LPAR;
                        end
                        CH_RPAR: begin
                            res_valid = 1'b1;
                            res_code  = TOK_RPAR;
                        end
                        CH_SPACE: ;
                        CH_EOL:   n_halted = 1'b1;
                        default: begin
                            res_valid = 1'b1;
                            res_err   = 1'b1;
                            n_halted  = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk        <= PK_IDLE;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pk     <= n_pk;
            r_halted <= n_halted;
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_valid) begin
            r_out_code <= res_code;
            r_out_err  <= res_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(8 - TOK_W){1'b0}}, r_out_code};
    assign o_m_tuser  = r_out_err;

endmodule

`default_nettype wire

### sv/lkt_checker.sv
`default_nettype none

module lkt_checker
    import lkt_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       o_s_tready,
    input wire logic [7:0] i_s_tdata,
    input wire logic       i_s_tuser,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tuser
);

    // an error result carries no token code
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[3:0] == TOK_NONE)
        else $error("error result with nonzero token code");

    // a good result carries a real token code and clean padding
    a_tok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |->
            o_m_tdata[3:0] != TOK_NONE && o_m_tdata[3:0] <= TOK_RPAR
            && o_m_tdata[7:4] == 4'd0)
        else $error("token code out of range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind logic_keyword_tokenizer lkt_checker u_lkt_checker (.*);

`default_nettype wire

### dv/logic_keyword_tokenizer_tb.sv
`default_nettype none

module logic_keyword_tokenizer_tb;
    import lkt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_CHARS  = 700;
    localparam int unsigned WATCHDOG_MAX  = 5000;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned HOLD_AT_TOKEN = 250;
    localparam int unsigned DRAIN_LINE    = 40;

    typedef struct packed {
        logic [3:0] kw;
        logic       halt;
    } t_scan_state;

    typedef struct packed {
        t_scan_state st;
        logic        looked;
        logic        has_tok;
        logic [3:0]  code;
        logic        err;
    } t_scan_result;

    typedef struct packed {
        logic [3:0] code;
        logic       err;
    } t_token;

    typedef struct packed {
        logic [7:0] ch;
        logic       sol;
        logic       drain;
    } t_char_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;   // [7:0] character
    logic       s_tuser = 1'b0; // [0] start_of_line
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;        // [3:0] token_code, [7:4] zero
    logic       m_tuser;        // [0] is_error

    t_char_req    pending_chars[$];
    t_token       expected_tokens[$];
    t_scan_state  gen_scan;
    t_scan_state  dut_scan;
    t_scan_result sent_res;
    t_char_req    next_req;
    t_token       want_tok;
    int unsigned  looked_cnt;
    int unsigned  sent_cnt;
    int unsigned  tokens_seen;
    int unsigned  fail_cnt;
    int unsigned  gap_left;
    int unsigned  stall_left;
    int unsigned  idle_cycles;
    bit           long_hold_done;

    logic_keyword_tokenizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the keyword scanner by one byte.
    function automatic t_scan_result scan_char(t_scan_state st, logic [7:0] ch, logic sol);
        t_scan_result r;
        logic         in_word;
        logic [7:0]   want;
        logic [3:0]   nxt;
        logic [3:0]   done_code;
        r = '0;
        r.st = st;
        in_word = 1'b1;
        want = CH_EOL;
        nxt = PK_IDLE;
        done_code = TOK_NONE;
        if (sol) begin
            r.st.halt = 1'b0;
            r.st.kw = PK_IDLE;
        end
        if (!r.st.halt) begin
            r.looked = 1'b1;
            case (r.st.kw)
                PK_N:   begin want = CH_O; nxt = PK_NO; end
                PK_NO:  begin want = CH_T; done_code = TOK_NOT; end
                PK_A:   begin want = CH_N; nxt = PK_AN; end
                PK_AN:  begin want = CH_D; done_code = TOK_AND; end
                PK_O:   begin want = CH_R; done_code = TOK_OR; end
                PK_X:   begin want = CH_O; nxt = PK_XO; end
                PK_XO:  begin want = CH_R; done_code = TOK_XOR; end
                PK_I:   begin want = CH_F; nxt = PK_IF; end
                PK_T:   begin want = CH_H; nxt = PK_TH; end
                PK_TH:  begin want = CH_E; nxt = PK_THE; end
                PK_THE: begin want = CH_N; done_code = TOK_THEN; end
                default: in_word = 1'b0;
            endcase
            if (in_word) begin
                if (ch != want) begin
                    r.has_tok = 1'b1;
                    r.err = 1'b1;
                end else if (done_code != TOK_NONE) begin
                    r.has_tok = 1'b1;
                    r.code = done_code;
                    r.st.kw = PK_IDLE;
                end else begin
                    r.st.kw = nxt;
                end
            end else if (r.st.kw == PK_IF) begin
                // "if" is only settled by the byte after it
                r.st.kw = PK_IDLE;
                r.has_tok = 1'b1;
                if (ch == CH_F) begin
                    r.code = TOK_IFF;
                end else if (ch == CH_SPACE) begin
                    r.code = TOK_IF;
                end else if (ch == CH_EOL) begin
                    r.code = TOK_IF;
                    r.st.halt = 1'b1;
                end else begin
                    r.err = 1'b1;
                end
            end else begin
                r.st.kw = PK_IDLE;
                case (ch)
                    CH_P, CH_Q, CH_R, CH_S: begin r.has_tok = 1'b1; r.code = TOK_VAR; end
                    CH_N:     r.st.kw = PK_N;
                    CH_A:     r.st.kw = PK_A;
                    CH_O:     r.st.kw = PK_O;
                    CH_X:     r.st.kw = PK_X;
                    CH_I:     r.st.kw = PK_I;
                    CH_T:     r.st.kw = PK_T;
                    CH_LPAR:  begin r.has_tok = 1'b1; r.code = TOK_LPAR; end
                    CH_RPAR:  begin r.has_tok = 1'b1; r.code = TOK_RPAR; end
                    CH_SPACE: ;
                    CH_EOL:   r.st.halt = 1'b1;
                    default:  begin r.has_tok = 1'b1; r.err = 1'b1; end
                endcase
            end
            if (r.err) begin
                r.code = TOK_NONE;
                r.st.halt = 1'b1;
                r.st.kw = PK_IDLE;
            end
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none during calm stretches.
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string pick_token();
        case ($urandom_range(0, 14))
            0:       return "p";
            1:       return "q";
            2:       return "r";
            3:       return "s";
            4:       return "not";
            5:       return "and";
            6:       return "or";
            7:       return "xor";
            8:       return "if ";
            9:       return "iff";
            10:      return "then";
            11:      return "(";
            12:      return ")";
            13:      return "if";
            default: return " ";
        endcase
    endfunction

    task automatic push_char(logic [7:0] ch, logic sol, logic drain);
        t_scan_result r;
        r = scan_char(gen_scan, ch, sol);
        gen_scan = r.st;
        if (r.looked)
            looked_cnt++;
        pending_chars.push_back('{ch: ch, sol: sol, drain: drain});
    endtask

    task automatic push_text(string s, bit sol_first);
        for (int j = 0; j < s.len(); j++)
            push_char(s[j], sol_first && (j == 0), 1'b0);
    endtask

    // Well-formed line with random content; a few bytes get corrupted.
    task automatic push_line(bit drain_first);
        int unsigned n;
        string       tok;
        logic [7:0]  ch;
        bit          first;
        first = 1'b1;
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            tok = pick_token();
            for (int j = 0; j < tok.len(); j++) begin
                ch = tok[j];
                if ($urandom_range(0, 99) < 3)
                    ch = 8'($urandom_range(0, 255));
                push_char(ch, first, first && drain_first);
                first = 1'b0;
            end
        end
        if ($urandom_range(0, 9) < 7)
            push_char(CH_EOL, 1'b0, 1'b0);
    endtask

    // sender: present queued bytes, predict tokens on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                sent_res = scan_char(dut_scan, s_tdata, s_tuser);
                dut_scan = sent_res.st;
                if (sent_res.has_tok)
                    expected_tokens.push_back({sent_res.code, sent_res.err});
                sent_cnt++;
                gap_left = pick_gap(((sent_cnt / 96) % 4) == 1);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() != 0 &&
                             (!pending_chars[0].drain || expected_tokens.size() == 0)) begin
                    next_req = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_req.ch;
                    s_tuser <= next_req.sol;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check tokens, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                tokens_seen++;
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: token_code %0d, is_error %0b",
                           m_tdata[3:0], m_tuser);
                    fail_cnt++;
                end else begin
                    want_tok = expected_tokens.pop_front();
                    if (m_tdata[3:0] !== want_tok.code) begin
                        $error("token_code: expected %0d, got %0d", want_tok.code, m_tdata[3:0]);
                        fail_cnt++;
                    end
                    if (m_tuser !== want_tok.err) begin
                        $error("is_error: expected %0b, got %0b", want_tok.err, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata[7:4] !== 4'd0) begin
                        $error("tdata padding: expected 0, got %0h", m_tdata[7:4]);
                        fail_cnt++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && tokens_seen >= HOLD_AT_TOKEN) begin
                // hold off long enough for the block to back up its input
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap(((tokens_seen / 96) % 4) == 3);
                if (stall_left == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int unsigned line_no;
        gen_scan = '0;
        dut_scan = '0;
        line_no = 0;

        // every keyword back to back: each but "if" ends on its last letter
        push_text("notandorxor", 1'b1);
        push_text("then(iff)", 1'b0);
        push_text("if ", 1'b0);
        // "if" closed by end of line, then a byte ignored while halted
        push_text("if", 1'b0);
        push_char(CH_EOL, 1'b0, 1'b0);
        push_text("z", 1'b0);
        // keyword broken by end of line
        push_text("an", 1'b1);
        push_char(CH_EOL, 1'b0, 1'b0);
        push_char(8'hFF, 1'b1, 1'b0);
        push_text("ifs", 1'b1);
        push_text(" p", 1'b1);
        push_char(CH_EOL, 1'b0, 1'b0);

        looked_cnt = 0;
        while (looked_cnt < RANDOM_CHARS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8))
                    push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
            end else begin
                push_line(line_no == 0 || line_no == DRAIN_LINE);
                line_no++;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_cnt == 0 && expected_tokens.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
